@@ hdl/pli_pkg.sv @@
// types, constants and control store of the piecewise-linear interpolator
package pli_pkg;

   localparam int VAL_W = 32;
   localparam int FRAC_W = 16;
   localparam int STEP_W = 6;
   localparam int QUO_W = 32;
   localparam int DIV_CNT_W = $clog2(QUO_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OPC_CLEAR  = 2'd0,
      OPC_APPEND = 2'd1,
      OPC_QUERY  = 2'd2,
      OPC_UNUSED = 2'd3
   } opcode_type;

   // datapath actions
   typedef enum logic [4:0] {
      A_NOP,
      A_CLEAR,
      A_APPEND,
      A_EMIT_ERR,
      A_LAT_LO,
      A_LAT_HI,
      A_LAT_LO_CI,
      A_RETREAT,
      A_ADVANCE,
      A_IDX_ZERO,
      A_DIV_INIT,
      A_DIV_PREP,
      A_DIV_STEP,
      A_DIV_DONE,
      A_SLOPE_SAT,
      A_DIFF,
      A_MUL,
      A_EMIT_SUM,
      A_EMIT_LO,
      A_EMIT_HI
   } act_type;

   // table read address select
   typedef enum logic [2:0] {
      RD_NONE,
      RD_FIRST,
      RD_LAST,
      RD_CI,
      RD_CI1,
      RD_NEXT,
      RD_PREV
   } rd_type;

   // branch conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_FULL,
      C_EMPTY,
      C_LE_LO,
      C_GE_HI,
      C_NO_CACHE,
      C_HIT,
      C_IDX_ZERO,
      C_HOLDS,
      C_NEXT_OUT,
      C_DIV_TRIVIAL,
      C_DIV_BUSY
   } cond_type;

   typedef struct packed {
      act_type             act;
      rd_type              rd;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
      logic                fin;
   } uword_type;

   typedef struct packed {
      logic    en;
      act_type act;
      rd_type  rd;
   } ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic le_lo;
      logic ge_hi;
      logic no_cache;
      logic hit;
      logic idx_zero;
      logic holds;
      logic next_out;
      logic div_trivial;
      logic div_busy;
      logic out_blocked;
   } stat_type;

   localparam logic [STEP_W-1:0] S_CLEAR      = STEP_W'(0);
   localparam logic [STEP_W-1:0] S_APPEND     = STEP_W'(1);
   localparam logic [STEP_W-1:0] S_APPEND_WR  = STEP_W'(2);
   localparam logic [STEP_W-1:0] S_ERR        = STEP_W'(3);
   localparam logic [STEP_W-1:0] S_QUERY      = STEP_W'(4);
   localparam logic [STEP_W-1:0] S_RD_LAST    = STEP_W'(5);
   localparam logic [STEP_W-1:0] S_CHK_LO     = STEP_W'(6);
   localparam logic [STEP_W-1:0] S_CHK_HI     = STEP_W'(7);
   localparam logic [STEP_W-1:0] S_CHK_CACHE  = STEP_W'(8);
   localparam logic [STEP_W-1:0] S_RD_CI1     = STEP_W'(9);
   localparam logic [STEP_W-1:0] S_LAT_CI1    = STEP_W'(10);
   localparam logic [STEP_W-1:0] S_CHK_HIT    = STEP_W'(11);
   localparam logic [STEP_W-1:0] S_CHK_DIR    = STEP_W'(12);
   localparam logic [STEP_W-1:0] S_BWD        = STEP_W'(13);
   localparam logic [STEP_W-1:0] S_BWD_LAT    = STEP_W'(14);
   localparam logic [STEP_W-1:0] S_BWD_CHK    = STEP_W'(15);
   localparam logic [STEP_W-1:0] S_BWD_LOOP   = STEP_W'(16);
   localparam logic [STEP_W-1:0] S_FWD_START  = STEP_W'(17);
   localparam logic [STEP_W-1:0] S_FWD_ADV    = STEP_W'(18);
   localparam logic [STEP_W-1:0] S_FWD        = STEP_W'(19);
   localparam logic [STEP_W-1:0] S_FWD_LAT    = STEP_W'(20);
   localparam logic [STEP_W-1:0] S_FWD_CHK    = STEP_W'(21);
   localparam logic [STEP_W-1:0] S_FWD_LOOP   = STEP_W'(22);
   localparam logic [STEP_W-1:0] S_SLOPE      = STEP_W'(23);
   localparam logic [STEP_W-1:0] S_DIV_PREP   = STEP_W'(24);
   localparam logic [STEP_W-1:0] S_DIV        = STEP_W'(25);
   localparam logic [STEP_W-1:0] S_DIV_DONE   = STEP_W'(26);
   localparam logic [STEP_W-1:0] S_DIFF       = STEP_W'(27);
   localparam logic [STEP_W-1:0] S_MUL        = STEP_W'(28);
   localparam logic [STEP_W-1:0] S_SUM        = STEP_W'(29);
   localparam logic [STEP_W-1:0] S_SLOPE_FIX  = STEP_W'(30);
   localparam logic [STEP_W-1:0] S_EMIT_LO    = STEP_W'(31);
   localparam logic [STEP_W-1:0] S_EMIT_HI    = STEP_W'(32);

   function automatic uword_type uw(act_type a, rd_type r, cond_type c,
                                    logic [STEP_W-1:0] t, logic f);
      uword_type w;
      w.act = a;
      w.rd = r;
      w.cond = c;
      w.target = t;
      w.fin = f;
      return w;
   endfunction

   // control store: one word per step, data read at a step is latched at the next
   function automatic uword_type ucode(logic [STEP_W-1:0] step);
      uword_type w;
      w = uw(A_NOP, RD_NONE, C_NEVER, S_CLEAR, 1'b1);
      unique case (step)
         S_CLEAR:     w = uw(A_CLEAR,     RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         S_APPEND:    w = uw(A_NOP,       RD_NONE,  C_FULL,        S_ERR,       1'b0);
         S_APPEND_WR: w = uw(A_APPEND,    RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         S_ERR:       w = uw(A_EMIT_ERR,  RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         S_QUERY:     w = uw(A_NOP,       RD_FIRST, C_EMPTY,       S_ERR,       1'b0);
         S_RD_LAST:   w = uw(A_LAT_LO,    RD_LAST,  C_NEVER,       S_CLEAR,     1'b0);
         S_CHK_LO:    w = uw(A_LAT_HI,    RD_NONE,  C_LE_LO,       S_EMIT_LO,   1'b0);
         S_CHK_HI:    w = uw(A_NOP,       RD_NONE,  C_GE_HI,       S_EMIT_HI,   1'b0);
         S_CHK_CACHE: w = uw(A_NOP,       RD_CI,    C_NO_CACHE,    S_FWD_START, 1'b0);
         S_RD_CI1:    w = uw(A_LAT_LO_CI, RD_CI1,   C_NEVER,       S_CLEAR,     1'b0);
         S_LAT_CI1:   w = uw(A_LAT_HI,    RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_CHK_HIT:   w = uw(A_NOP,       RD_NONE,  C_HIT,         S_DIFF,      1'b0);
         S_CHK_DIR:   w = uw(A_NOP,       RD_NONE,  C_GE_HI,       S_FWD_ADV,   1'b0);
         S_BWD:       w = uw(A_RETREAT,   RD_PREV,  C_IDX_ZERO,    S_ERR,       1'b0);
         S_BWD_LAT:   w = uw(A_LAT_LO,    RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_BWD_CHK:   w = uw(A_NOP,       RD_NONE,  C_HOLDS,       S_SLOPE,     1'b0);
         S_BWD_LOOP:  w = uw(A_NOP,       RD_NONE,  C_ALWAYS,      S_BWD,       1'b0);
         S_FWD_START: w = uw(A_IDX_ZERO,  RD_NONE,  C_ALWAYS,      S_FWD,       1'b0);
         S_FWD_ADV:   w = uw(A_ADVANCE,   RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_FWD:       w = uw(A_NOP,       RD_NEXT,  C_NEXT_OUT,    S_ERR,       1'b0);
         S_FWD_LAT:   w = uw(A_LAT_HI,    RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_FWD_CHK:   w = uw(A_NOP,       RD_NONE,  C_HOLDS,       S_SLOPE,     1'b0);
         S_FWD_LOOP:  w = uw(A_NOP,       RD_NONE,  C_ALWAYS,      S_FWD_ADV,   1'b0);
         S_SLOPE:     w = uw(A_DIV_INIT,  RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_DIV_PREP:  w = uw(A_DIV_PREP,  RD_NONE,  C_DIV_TRIVIAL, S_SLOPE_FIX, 1'b0);
         S_DIV:       w = uw(A_DIV_STEP,  RD_NONE,  C_DIV_BUSY,    S_DIV,       1'b0);
         S_DIV_DONE:  w = uw(A_DIV_DONE,  RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_DIFF:      w = uw(A_DIFF,      RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_MUL:       w = uw(A_MUL,       RD_NONE,  C_NEVER,       S_CLEAR,     1'b0);
         S_SUM:       w = uw(A_EMIT_SUM,  RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         S_SLOPE_FIX: w = uw(A_SLOPE_SAT, RD_NONE,  C_ALWAYS,      S_DIFF,      1'b0);
         S_EMIT_LO:   w = uw(A_EMIT_LO,   RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         S_EMIT_HI:   w = uw(A_EMIT_HI,   RD_NONE,  C_NEVER,       S_CLEAR,     1'b1);
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] entry_step(opcode_type op);
      logic [STEP_W-1:0] s;
      unique case (op)
         OPC_CLEAR:  s = S_CLEAR;
         OPC_APPEND: s = S_APPEND;
         OPC_QUERY:  s = S_QUERY;
         OPC_UNUSED: s = S_CLEAR;
         default:    s = S_CLEAR;
      endcase
      return s;
   endfunction

endpackage

@@ hdl/pli_req_if.sv @@
// request channel: opcode and point or query coordinates
interface pli_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              opcode;
   logic signed [pli_pkg::VAL_W-1:0]        x_value;
   logic signed [pli_pkg::VAL_W-1:0]        y_value;

   modport source (output valid, output opcode, output x_value, output y_value,
                   input ready);
   modport sink (input valid, input opcode, input x_value, input y_value,
                 output ready);
endinterface

@@ hdl/pli_rsp_if.sv @@
// response channel: interpolated value and error flag
interface pli_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [pli_pkg::VAL_W-1:0]        result_value;
   logic                                    error_flag;

   modport source (output valid, output result_value, output error_flag, input ready);
   modport sink (input valid, input result_value, input error_flag, output ready);
endinterface

@@ hdl/pli_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pli_seq.sv @@
// microcode sequencer: step counter, control store lookup and branch logic
module pli_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   input  pli_pkg::stat_type   stat,
   output logic                req_ready,
   output pli_pkg::ctl_type    ctl
);

   logic                        busy_ff, busy_in;
   logic [pli_pkg::STEP_W-1:0]  step_ff, step_in;
   pli_pkg::uword_type          word;
   pli_pkg::opcode_type         opc;
   logic                        cond_true;
   logic                        hold;

   assign word = pli_pkg::ucode(step_ff);
   assign opc = pli_pkg::opcode_type'(req_opcode);

   always_comb begin
      unique case (word.cond)
         pli_pkg::C_NEVER:       cond_true = 1'b0;
         pli_pkg::C_ALWAYS:      cond_true = 1'b1;
         pli_pkg::C_FULL:        cond_true = stat.full;
         pli_pkg::C_EMPTY:       cond_true = stat.empty;
         pli_pkg::C_LE_LO:       cond_true = stat.le_lo;
         pli_pkg::C_GE_HI:       cond_true = stat.ge_hi;
         pli_pkg::C_NO_CACHE:    cond_true = stat.no_cache;
         pli_pkg::C_HIT:         cond_true = stat.hit;
         pli_pkg::C_IDX_ZERO:    cond_true = stat.idx_zero;
         pli_pkg::C_HOLDS:       cond_true = stat.holds;
         pli_pkg::C_NEXT_OUT:    cond_true = stat.next_out;
         pli_pkg::C_DIV_TRIVIAL: cond_true = stat.div_trivial;
         pli_pkg::C_DIV_BUSY:    cond_true = stat.div_busy;
         default:                cond_true = 1'b0;
      endcase
   end

   // a result step waits while the output register still holds an untaken transaction
   assign hold = stat.out_blocked &&
                 (word.act == pli_pkg::A_EMIT_ERR || word.act == pli_pkg::A_EMIT_SUM ||
                  word.act == pli_pkg::A_EMIT_LO || word.act == pli_pkg::A_EMIT_HI);

   assign req_ready = !busy_ff;
   assign ctl.en = busy_ff && !hold;
   assign ctl.act = word.act;
   assign ctl.rd = word.rd;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = (opc != pli_pkg::OPC_UNUSED);
            step_in = pli_pkg::entry_step(opc);
         end
      end else if (!hold) begin
         if (word.fin) begin
            busy_in = 1'b0;
         end else if (cond_true) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + pli_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= pli_pkg::S_CLEAR;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

@@ hdl/pli_dp.sv @@
// datapath: point tables, interval search registers, slope divider, multiply and output
module pli_dp #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [pli_pkg::VAL_W-1:0]    req_x,
   input  logic signed [pli_pkg::VAL_W-1:0]    req_y,
   input  pli_pkg::ctl_type                    ctl,
   output pli_pkg::stat_type                   stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [pli_pkg::VAL_W-1:0]    rsp_value,
   output logic                                rsp_error
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int VW = pli_pkg::VAL_W;
   localparam int FW = pli_pkg::FRAC_W;
   localparam int PROD_W = 2 * VW + 1;
   localparam int SUM_W = PROD_W - FW + 1;

   // control state
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          ci_ff, ci_in;
   logic                      cache_valid_ff, cache_valid_in;
   logic signed [VW-1:0]      slope_ff, slope_in;
   logic                      out_valid_ff, out_valid_in;

   // working registers
   logic signed [VW-1:0]      x_q_ff, x_q_in;
   logic signed [VW-1:0]      y_q_ff, y_q_in;
   logic signed [VW-1:0]      lo_x_ff, lo_x_in, lo_y_ff, lo_y_in;
   logic signed [VW-1:0]      hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [VW-1:0]             dx_ff, dx_in;
   logic [VW-1:0]             ady_ff, ady_in;
   logic                      neg_ff, neg_in;
   logic [VW-1:0]             rem_ff, rem_in;
   logic [VW-1:0]             quo_ff, quo_in;
   logic [pli_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic signed [VW:0]        diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [VW-1:0]      out_value_ff, out_value_in;
   logic                      out_error_ff, out_error_in;

   // ram ports
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          rd_addr;
   logic [CNT_W-1:0]          count_m1;
   logic [VW-1:0]             rx, ry;

   // arithmetic
   logic signed [VW:0]        dx_full, dy_full, ady_full;
   logic [VW:0]               trial, trial_sub;
   logic                      fits;
   logic signed [PROD_W-1:0]  prod_next;
   logic signed [SUM_W-1:0]   sum;
   logic signed [VW-1:0]      sum_sat;
   logic signed [VW-1:0]      div_slope;

   assign wr_en = ctl.en && (ctl.act == pli_pkg::A_APPEND);
   assign wr_addr = count_ff[IDX_W-1:0];
   assign count_m1 = count_ff - CNT_W'(1);

   always_comb begin
      unique case (ctl.rd)
         pli_pkg::RD_NONE:  rd_addr = '0;
         pli_pkg::RD_FIRST: rd_addr = '0;
         pli_pkg::RD_LAST:  rd_addr = count_m1[IDX_W-1:0];
         pli_pkg::RD_CI:    rd_addr = ci_ff;
         pli_pkg::RD_CI1:   rd_addr = ci_ff + IDX_W'(1);
         pli_pkg::RD_NEXT:  rd_addr = idx_ff + IDX_W'(1);
         pli_pkg::RD_PREV:  rd_addr = idx_ff - IDX_W'(1);
         default:           rd_addr = '0;
      endcase
   end

   pli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) x_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (x_q_ff),
      .rd_addr (rd_addr),
      .rd_data (rx)
   );

   pli_ram #(.WIDTH(VW), .DEPTH(TABLE_DEPTH)) y_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (y_q_ff),
      .rd_addr (rd_addr),
      .rd_data (ry)
   );

   assign dx_full = {hi_x_ff[VW-1], hi_x_ff} - {lo_x_ff[VW-1], lo_x_ff};
   assign dy_full = {hi_y_ff[VW-1], hi_y_ff} - {lo_y_ff[VW-1], lo_y_ff};
   assign ady_full = dy_full[VW] ? -dy_full : dy_full;

   // one restoring division step, quotient bits shift in below the numerator bits
   assign trial = {rem_ff, quo_ff[VW-1]};
   assign fits = (trial >= {1'b0, dx_ff});
   assign trial_sub = trial - {1'b0, dx_ff};

   always_comb begin
      if (neg_ff) begin
         div_slope = (quo_ff > VW'(pli_pkg::VAL_MIN)) ? pli_pkg::VAL_MIN : -$signed(quo_ff);
      end else begin
         div_slope = quo_ff[VW-1] ? pli_pkg::VAL_MAX : $signed(quo_ff);
      end
   end

   assign prod_next = diff_ff * slope_ff;

   // arithmetic shift of the product rounds toward minus infinity
   assign sum = SUM_W'(lo_y_ff) + SUM_W'($signed(prod_ff[PROD_W-1:FW]));

   always_comb begin
      if (sum > SUM_W'(pli_pkg::VAL_MAX)) begin
         sum_sat = pli_pkg::VAL_MAX;
      end else if (sum < SUM_W'(pli_pkg::VAL_MIN)) begin
         sum_sat = pli_pkg::VAL_MIN;
      end else begin
         sum_sat = sum[VW-1:0];
      end
   end

   always_comb begin
      count_in = count_ff;
      ci_in = ci_ff;
      cache_valid_in = cache_valid_ff;
      slope_in = slope_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      x_q_in = x_q_ff;
      y_q_in = y_q_ff;
      lo_x_in = lo_x_ff;
      lo_y_in = lo_y_ff;
      hi_x_in = hi_x_ff;
      hi_y_in = hi_y_ff;
      idx_in = idx_ff;
      dx_in = dx_ff;
      ady_in = ady_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_cnt_in = div_cnt_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      out_value_in = out_value_ff;
      out_error_in = out_error_ff;

      if (accept) begin
         x_q_in = req_x;
         y_q_in = req_y;
      end

      if (ctl.en) begin
         unique case (ctl.act)
            pli_pkg::A_NOP: ;
            pli_pkg::A_CLEAR: begin
               count_in = '0;
               cache_valid_in = 1'b0;
               ci_in = '0;
               slope_in = '0;
            end
            pli_pkg::A_APPEND: begin
               count_in = count_ff + CNT_W'(1);
               cache_valid_in = 1'b0;
            end
            pli_pkg::A_EMIT_ERR: begin
               out_valid_in = 1'b1;
               out_value_in = '0;
               out_error_in = 1'b1;
            end
            pli_pkg::A_LAT_LO: begin
               lo_x_in = rx;
               lo_y_in = ry;
            end
            pli_pkg::A_LAT_HI: begin
               hi_x_in = rx;
               hi_y_in = ry;
            end
            pli_pkg::A_LAT_LO_CI: begin
               lo_x_in = rx;
               lo_y_in = ry;
               idx_in = ci_ff;
            end
            pli_pkg::A_RETREAT: begin
               hi_x_in = lo_x_ff;
               hi_y_in = lo_y_ff;
               idx_in = idx_ff - IDX_W'(1);
            end
            pli_pkg::A_ADVANCE: begin
               lo_x_in = hi_x_ff;
               lo_y_in = hi_y_ff;
               idx_in = idx_ff + IDX_W'(1);
            end
            pli_pkg::A_IDX_ZERO: begin
               idx_in = '0;
            end
            pli_pkg::A_DIV_INIT: begin
               dx_in = dx_full[VW-1:0];
               ady_in = ady_full[VW-1:0];
               neg_in = dy_full[VW];
               ci_in = idx_ff;
               cache_valid_in = 1'b1;
            end
            pli_pkg::A_DIV_PREP: begin
               // numerator is |dy| << 16; its top part starts as the partial remainder
               rem_in = {{FW{1'b0}}, ady_ff[VW-1:FW]};
               quo_in = {ady_ff[FW-1:0], {FW{1'b0}}};
               div_cnt_in = '0;
            end
            pli_pkg::A_DIV_STEP: begin
               rem_in = fits ? trial_sub[VW-1:0] : trial[VW-1:0];
               quo_in = {quo_ff[VW-2:0], fits};
               div_cnt_in = div_cnt_ff + pli_pkg::DIV_CNT_W'(1);
            end
            pli_pkg::A_DIV_DONE: begin
               slope_in = div_slope;
            end
            pli_pkg::A_SLOPE_SAT: begin
               if (dx_ff == '0) begin
                  slope_in = '0;
               end else begin
                  slope_in = neg_ff ? pli_pkg::VAL_MIN : pli_pkg::VAL_MAX;
               end
            end
            pli_pkg::A_DIFF: begin
               diff_in = {x_q_ff[VW-1], x_q_ff} - {lo_x_ff[VW-1], lo_x_ff};
            end
            pli_pkg::A_MUL: begin
               prod_in = prod_next;
            end
            pli_pkg::A_EMIT_SUM: begin
               out_valid_in = 1'b1;
               out_value_in = sum_sat;
               out_error_in = 1'b0;
            end
            pli_pkg::A_EMIT_LO: begin
               out_valid_in = 1'b1;
               out_value_in = lo_y_ff;
               out_error_in = 1'b0;
            end
            pli_pkg::A_EMIT_HI: begin
               out_valid_in = 1'b1;
               out_value_in = hi_y_ff;
               out_error_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ci_ff <= '0;
         cache_valid_ff <= 1'b0;
         slope_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ci_ff <= ci_in;
         cache_valid_ff <= cache_valid_in;
         slope_ff <= slope_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_q_ff <= x_q_in;
      y_q_ff <= y_q_in;
      lo_x_ff <= lo_x_in;
      lo_y_ff <= lo_y_in;
      hi_x_ff <= hi_x_in;
      hi_y_ff <= hi_y_in;
      idx_ff <= idx_in;
      dx_ff <= dx_in;
      ady_ff <= ady_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_cnt_ff <= div_cnt_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      out_value_ff <= out_value_in;
      out_error_ff <= out_error_in;
   end

   assign stat.full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign stat.le_lo = (x_q_ff <= lo_x_ff);
   assign stat.ge_hi = (x_q_ff >= hi_x_ff);
   assign stat.no_cache = !cache_valid_ff || (CNT_W'(ci_ff) + CNT_W'(1) >= count_ff);
   assign stat.hit = (lo_x_ff <= x_q_ff) && (x_q_ff < hi_x_ff);
   assign stat.idx_zero = (idx_ff == '0);
   assign stat.holds = (lo_x_ff <= x_q_ff) && (x_q_ff <= hi_x_ff);
   assign stat.next_out = (CNT_W'(idx_ff) + CNT_W'(1) >= count_ff);
   assign stat.div_trivial = (dx_ff == '0) || ({{FW{1'b0}}, ady_ff[VW-1:FW]} >= dx_ff);
   assign stat.div_busy = (div_cnt_ff != pli_pkg::DIV_LAST);
   assign stat.out_blocked = out_valid_ff && !rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_error = out_error_ff;

endmodule

@@ hdl/piecewise_linear_interpolator_top.sv @@
// top level of the piecewise-linear interpolator
// Holds up to TABLE_DEPTH (x, y) points in two memories with one write and one read port
// and answers interpolation queries in signed Q16.16. One transaction is worked on at a
// time by a microcoded sequencer; the result sits in an output register, so the next
// request is taken while that result waits. Request ready returns the cycle after the
// last step. An append checks for a full table before it writes. A query at or below the
// first point or at or above the last point answers that point's y; a query that falls
// in the cached interval goes straight to the difference, product and sum with the
// cached slope. Any other query walks the table from the cached interval (or from the
// start after a clear or append), point by point backward or forward, works out the
// slope in the bit-serial divider and then the product and sum; a zero-width interval
// or a slope too large for the divider's quotient skips the divider. Failed searches,
// queries of an empty table and appends to a full table return value zero with the
// error flag set. The point memories are not cleared and need no initialization.
module piecewise_linear_interpolator_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   pli_req_if.sink     req_bus,
   pli_rsp_if.source   rsp_bus
);

   pli_pkg::ctl_type  ctl;
   pli_pkg::stat_type stat;
   logic              accept;

   assign accept = req_bus.valid && req_bus.ready;

   pli_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .stat       (stat),
      .req_ready  (req_bus.ready),
      .ctl        (ctl)
   );

   pli_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_x     (req_bus.x_value),
      .req_y     (req_bus.y_value),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_value (rsp_bus.result_value),
      .rsp_error (rsp_bus.error_flag)
   );

endmodule

@@ tb/sv/tb_piecewise_linear_interpolator_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the piecewise-linear interpolator: directed and random traffic
module tb_piecewise_linear_interpolator_top;

   localparam int TABLE_DEPTH = 1024;
   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_OFF = 400;

   typedef struct {
      pli_pkg::opcode_type              op;
      logic signed [pli_pkg::VAL_W-1:0] x_value;
      logic signed [pli_pkg::VAL_W-1:0] y_value;
   } op_item_type;

   typedef struct {
      logic signed [pli_pkg::VAL_W-1:0] value;
      logic                             err;
   } answer_type;

   logic clock;
   logic reset;

   pli_req_if req_bus ();
   pli_rsp_if rsp_bus ();

   piecewise_linear_interpolator_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   op_item_type queued_ops[$];
   answer_type  expected_answers[$];
   longint      plan_x[$];

   // predicted table and interval cache
   logic signed [pli_pkg::VAL_W-1:0] x_tab [TABLE_DEPTH];
   logic signed [pli_pkg::VAL_W-1:0] y_tab [TABLE_DEPTH];
   int unsigned                      pt_count = 0;
   int unsigned                      span_idx = 0;
   bit                               span_known = 1'b0;
   logic signed [pli_pkg::VAL_W-1:0] span_slope = '0;

   int unsigned err_count = 0;
   int unsigned answers_seen = 0;
   int unsigned quiet_cycles = 0;
   int unsigned cyc = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic signed [pli_pkg::VAL_W-1:0] sat_val(longint v);
      if (v > longint'(pli_pkg::VAL_MAX)) return pli_pkg::VAL_MAX;
      if (v < longint'(pli_pkg::VAL_MIN)) return pli_pkg::VAL_MIN;
      return v[pli_pkg::VAL_W-1:0];
   endfunction

   function automatic bit covers(int unsigned i, longint xq);
      return longint'(x_tab[i]) <= xq && xq <= longint'(x_tab[i+1]);
   endfunction

   function automatic logic signed [pli_pkg::VAL_W-1:0] seg_slope(int unsigned i);
      longint dx, dy;
      dx = longint'(x_tab[i+1]) - longint'(x_tab[i]);
      dy = longint'(y_tab[i+1]) - longint'(y_tab[i]);
      if (dx == 0) return '0;
      return sat_val((dy * 65536) / dx);
   endfunction

   function automatic void post_answer(logic signed [pli_pkg::VAL_W-1:0] v, logic e);
      answer_type a;
      a.value = v;
      a.err = e;
      expected_answers = {expected_answers, a};
   endfunction

   function automatic void interpolate(longint xq);
      int unsigned n, at, i;
      bit          found;
      longint      p;
      n = pt_count;
      if (n == 0) begin
         post_answer('0, 1'b1);
         return;
      end
      if (xq <= longint'(x_tab[0])) begin
         post_answer(y_tab[0], 1'b0);
         return;
      end
      if (xq >= longint'(x_tab[n-1])) begin
         post_answer(y_tab[n-1], 1'b0);
         return;
      end
      if (!(span_known && span_idx + 1 < n && longint'(x_tab[span_idx]) <= xq &&
            xq < longint'(x_tab[span_idx+1]))) begin
         found = 1'b0;
         at = 0;
         if (!span_known || span_idx + 1 >= n) begin
            for (i = 0; i + 1 < n; i++)
               if (!found && covers(i, xq)) begin
                  at = i;
                  found = 1'b1;
               end
         end else if (xq >= longint'(x_tab[span_idx+1])) begin
            for (i = span_idx + 1; i + 1 < n; i++)
               if (!found && covers(i, xq)) begin
                  at = i;
                  found = 1'b1;
               end
         end else begin
            for (i = span_idx; i > 0; i--)
               if (!found && covers(i - 1, xq)) begin
                  at = i - 1;
                  found = 1'b1;
               end
         end
         if (!found) begin
            post_answer('0, 1'b1);
            return;
         end
         span_idx = at;
         span_known = 1'b1;
         span_slope = seg_slope(at);
      end
      // exact 64-bit product, arithmetic shift floors it
      p = longint'(span_slope) * (xq - longint'(x_tab[span_idx]));
      post_answer(sat_val(longint'(y_tab[span_idx]) + (p >>> 16)), 1'b0);
   endfunction

   function automatic void apply_op(op_item_type it);
      case (it.op)
         pli_pkg::OPC_CLEAR: begin
            pt_count = 0;
            span_known = 1'b0;
            span_idx = 0;
            span_slope = '0;
         end
         pli_pkg::OPC_APPEND: begin
            if (pt_count >= TABLE_DEPTH) begin
               post_answer('0, 1'b1);
            end else begin
               x_tab[pt_count] = it.x_value;
               y_tab[pt_count] = it.y_value;
               pt_count++;
               span_known = 1'b0;
            end
         end
         pli_pkg::OPC_QUERY: interpolate(longint'(it.x_value));
         default: ;
      endcase
   endfunction

   function automatic void add_op(pli_pkg::opcode_type op,
                                  logic signed [pli_pkg::VAL_W-1:0] xv,
                                  logic signed [pli_pkg::VAL_W-1:0] yv);
      op_item_type it;
      it.op = op;
      it.x_value = xv;
      it.y_value = yv;
      queued_ops = {queued_ops, it};
   endfunction

   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned r, span;
      r = {$urandom, $urandom};
      span = hi - lo + 1;
      return lo + longint'(r % span);
   endfunction

   function automatic longint pick_y();
      if ($urandom_range(0, 2) == 0) return longint'($signed($urandom));
      return rand_between(-(1 << 20), 1 << 20);
   endfunction

   function automatic bit may_idle();
      return (cyc % 600) >= 150 && queued_ops.size() > 150;
   endfunction

   task automatic directed_checks();
      add_op(pli_pkg::OPC_QUERY, '0, '0);
      add_op(pli_pkg::OPC_UNUSED, pli_pkg::VAL_MAX, pli_pkg::VAL_MIN);
      // single point answers its y everywhere
      add_op(pli_pkg::OPC_APPEND, 5 << 16, -(3 << 16));
      add_op(pli_pkg::OPC_QUERY, pli_pkg::VAL_MIN, '0);
      add_op(pli_pkg::OPC_QUERY, 5 << 16, '1);
      add_op(pli_pkg::OPC_QUERY, pli_pkg::VAL_MAX, '0);
      add_op(pli_pkg::OPC_CLEAR, '0, '0);
      add_op(pli_pkg::OPC_APPEND, pli_pkg::VAL_MIN, pli_pkg::VAL_MAX);
      add_op(pli_pkg::OPC_APPEND, '0, pli_pkg::VAL_MIN);
      add_op(pli_pkg::OPC_APPEND, '0, 7 << 16);
      add_op(pli_pkg::OPC_APPEND, 10 << 16, -(3 << 16));
      add_op(pli_pkg::OPC_APPEND, pli_pkg::VAL_MAX, pli_pkg::VAL_MAX);
      add_op(pli_pkg::OPC_QUERY, pli_pkg::VAL_MIN, '0);
      add_op(pli_pkg::OPC_QUERY, pli_pkg::VAL_MAX, '0);
      add_op(pli_pkg::OPC_QUERY, -5, '0);
      // zero-width interval, then forward, hit, backward, forward again
      add_op(pli_pkg::OPC_QUERY, '0, '0);
      add_op(pli_pkg::OPC_QUERY, 5 << 16, '0);
      add_op(pli_pkg::OPC_QUERY, (3 << 16) + 12345, '0);
      add_op(pli_pkg::OPC_QUERY, -(1 << 20), '0);
      add_op(pli_pkg::OPC_QUERY, 20 << 16, '0);
      add_op(pli_pkg::OPC_QUERY, 10 << 16, '0);
      add_op(pli_pkg::OPC_UNUSED, '0, '0);
   endtask

   task automatic make_table(int k);
      int     mode;
      bit     scrambled;
      longint xv, step_max;
      mode = $urandom_range(0, 3);
      scrambled = ($urandom_range(0, 7) == 0);
      step_max = (mode == 0) ? 256 : (mode == 1) ? 65536 : (mode == 2) ? (1 << 22) : (1 << 29);
      xv = (mode == 3) ? longint'(pli_pkg::VAL_MIN) + longint'($urandom_range(0, 1 << 20))
                       : longint'($signed($urandom)) >>> 4;
      add_op(pli_pkg::OPC_CLEAR, $urandom, $urandom);
      plan_x.delete();
      for (int i = 0; i < k; i++) begin
         if (scrambled) xv = longint'($signed($urandom));
         else if (i > 0 && $urandom_range(0, 7) != 0) xv = xv + rand_between(1, step_max);
         xv = longint'(sat_val(xv));
         plan_x = {plan_x, xv};
         add_op(pli_pkg::OPC_APPEND, sat_val(xv), sat_val(pick_y()));
      end
   endtask

   task automatic make_queries(int m);
      longint lo, hi, span, stride, xq;
      int     style, pick;
      lo = -100000;
      hi = 100000;
      if (plan_x.size() != 0) begin
         lo = plan_x[0];
         hi = plan_x[0];
         foreach (plan_x[i]) begin
            if (plan_x[i] < lo) lo = plan_x[i];
            if (plan_x[i] > hi) hi = plan_x[i];
         end
      end
      span = hi - lo;
      stride = span / m;
      style = $urandom_range(0, 3);
      xq = lo;
      for (int j = 0; j < m; j++) begin
         pick = $urandom_range(0, 9);
         case (style)
            0: xq = lo + span * j / m + rand_between(0, stride);
            1: xq = hi - span * j / m - rand_between(0, stride);
            2: begin
               if (pick < 5) xq = rand_between(lo, hi);
               else if (pick == 5 && plan_x.size() != 0)
                  xq = plan_x[$urandom_range(0, plan_x.size() - 1)];
               else if (pick == 6) xq = lo - rand_between(0, 1 << 18);
               else if (pick == 7) xq = hi + rand_between(0, 1 << 18);
               else xq = longint'($signed($urandom));
            end
            // small steps stay mostly inside the cached interval
            default: xq = (j == 0) ? rand_between(lo, hi) : xq + rand_between(0, 255);
         endcase
         add_op(pli_pkg::OPC_QUERY, sat_val(xq), $urandom);
      end
   endtask

   task automatic random_traffic(int n_items);
      int     stop_at, kind, extra;
      longint xv;
      stop_at = queued_ops.size() + n_items;
      while (queued_ops.size() < stop_at) begin
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            add_op(pli_pkg::OPC_UNUSED, $urandom, $urandom);
         end else if (kind == 1) begin
            add_op(pli_pkg::OPC_CLEAR, $urandom, $urandom);
            plan_x.delete();
            make_queries(2);
         end else if (kind == 2) begin
            make_table(1);
            make_queries(4);
         end else if (kind == 3 && plan_x.size() != 0) begin
            // grow the current table without a clear
            xv = plan_x[$];
            extra = $urandom_range(1, 3);
            for (int i = 0; i < extra; i++) begin
               xv = longint'(sat_val(xv + rand_between(0, 1 << 20)));
               plan_x = {plan_x, xv};
               add_op(pli_pkg::OPC_APPEND, sat_val(xv), sat_val(pick_y()));
            end
            make_queries($urandom_range(2, 8));
         end else begin
            make_table($urandom_range(2, 12));
            make_queries($urandom_range(4, 20));
         end
      end
   endtask

   task automatic offer_head();
      req_bus.valid <= 1'b1;
      req_bus.opcode <= queued_ops[0].op;
      req_bus.x_value <= queued_ops[0].x_value;
      req_bus.y_value <= queued_ops[0].y_value;
   endtask

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_bus.valid && req_bus.ready) begin
         apply_op(queued_ops.pop_front());
         if (queued_ops.size() != 0 && !(may_idle() && $urandom_range(0, 3) == 0)) begin
            offer_head();
         end else begin
            req_bus.valid <= 1'b0;
            req_gap <= (queued_ops.size() != 0) ? $urandom_range(0, 3) : 0;
         end
      end else if (!req_bus.valid) begin
         if (req_gap != 0) req_gap <= req_gap - 1;
         else if (queued_ops.size() != 0) offer_head();
      end
   end

   always @(posedge clock) begin : pace_results
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= (hold_left == 1);
      end else if (!hold_done && answers_seen >= 60) begin
         // long back-pressure so the request side backs up
         hold_done <= 1'b1;
         hold_left <= HOLD_OFF;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= (rsp_stall == 1);
      end else if (may_idle() && $urandom_range(0, 5) == 0) begin
         rsp_stall <= $urandom_range(1, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         answers_seen <= answers_seen + 1;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected transaction: result_value %h error_flag %b", $time,
                     rsp_bus.result_value, rsp_bus.error_flag);
            err_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_bus.result_value !== want.value) begin
               $display("%0t: result_value expected %h got %h", $time, want.value,
                        rsp_bus.result_value);
               err_count++;
            end
            if (rsp_bus.error_flag !== want.err) begin
               $display("%0t: error_flag expected %b got %b", $time, want.err,
                        rsp_bus.error_flag);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cyc <= cyc + 1;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("tb_piecewise_linear_interpolator_top: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = pli_pkg::OPC_CLEAR;
      req_bus.x_value = '0;
      req_bus.y_value = '0;
      rsp_bus.ready = 1'b0;
      directed_checks();
      random_traffic(430);
      random_traffic(500);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (queued_ops.size() != 0 || req_bus.valid || expected_answers.size() != 0);
      repeat (60) @(posedge clock);
      if (err_count == 0)
         $display("tb_piecewise_linear_interpolator_top: clean");
      else
         $display("tb_piecewise_linear_interpolator_top: errors");
      $finish;
   end

endmodule

@@ piecewise_linear_interpolator_top.f @@
hdl/pli_pkg.sv
hdl/pli_req_if.sv
hdl/pli_rsp_if.sv
hdl/pli_ram.sv
hdl/pli_seq.sv
hdl/pli_dp.sv
hdl/piecewise_linear_interpolator_top.sv
tb/sv/tb_piecewise_linear_interpolator_top.sv
